[rtl/core/odo_pkg.sv]
package odo_pkg;

   localparam int POSITION_BITS   = 48;
   localparam int CORDIC_ITER_DEF = 16;
   localparam int ATAN_ENTRIES    = 24;

   localparam logic [33:0] CORDIC_GAIN   = 34'd652032874;
   localparam logic [26:0] HEADING_GAIN  = 27'd91746578;
   localparam logic [63:0] POS_HALF      = 64'd64000000000;
   // The position divisor is 2^16 * 1953125. After dropping 16 bits, the
   // rest is a multiply by ceil(2^69 / 1953125) and a shift by 69, which is
   // exact for every numerator below 2^48.
   localparam logic [48:0] POS_RECIP     = 49'd302231454903658;
   // The position quotient always fits in this many bits.
   localparam int          QUOT_BITS     = 26;

   typedef struct packed {
      logic        [62:0] stamp_ns;
      logic signed [15:0] speed;
      logic signed [15:0] turn_rate;
   } req_type;

   typedef struct packed {
      logic        [62:0]              stamp_out;
      logic signed [POSITION_BITS-1:0] pos_x;
      logic signed [POSITION_BITS-1:0] pos_y;
      logic signed [31:0]              heading;
      logic signed [15:0]              quat_z;
      logic signed [15:0]              quat_w;
      logic signed [15:0]              speed_out;
      logic signed [15:0]              turn_rate_out;
   } rsp_type;

   typedef struct packed {
      logic        [62:0] stamp;
      logic signed [15:0] speed;
      logic signed [15:0] turn_rate;
      logic        [31:0] dt;
   } job_type;

   // Arctangent table, 2^32 counts per turn.
   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   // Q2.30 to Q1.15, rounding half away from zero.
   function automatic logic signed [17:0] round15(input logic signed [33:0] v);
      logic [33:0] mag;
      logic [33:0] m;
      mag = v[33] ? 34'(-v) : 34'(v);
      m   = (mag + 34'd16384) >> 15;
      return v[33] ? 18'(-m) : 18'(m);
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v > 18'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -18'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = 16'(v);
      end
      return r;
   endfunction

endpackage

[rtl/core/odo_fifo.sv]
module odo_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_wr) begin
         wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wptr_ff + 1'b1);
      end
      if (do_rd) begin
         rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(rptr_ff + 1'b1);
      end
      if (do_wr && !do_rd) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (do_rd && !do_wr) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wptr_ff] <= wr_data;
      end
   end

endmodule

[rtl/core/odo_front.sv]
module odo_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  odo_pkg::req_type  req_data,
   input  logic              job_full,
   output logic              full,
   output logic              job_push,
   output odo_pkg::job_type  job_data
);
   logic [62:0] last_stamp_ff, last_stamp_in;
   logic [62:0] diff;
   logic        accept;
   logic        later;

   assign full   = job_full;
   assign accept = push && !job_full;
   assign later  = (last_stamp_ff != '0) && (req_data.stamp_ns > last_stamp_ff);
   assign diff   = req_data.stamp_ns - last_stamp_ff;

   assign job_push           = accept && later;
   assign job_data.stamp     = req_data.stamp_ns;
   assign job_data.speed     = req_data.speed;
   assign job_data.turn_rate = req_data.turn_rate;
   assign job_data.dt        = (diff[62:32] != '0) ? 32'hffff_ffff : diff[31:0];

   // Every accepted request updates the stamp, even one that yields no pose.
   assign last_stamp_in = accept ? req_data.stamp_ns : last_stamp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_stamp_ff <= '0;
      end else begin
         last_stamp_ff <= last_stamp_in;
      end
   end

endmodule

[rtl/core/odo_cordic.sv]
module odo_cordic #(
   parameter int CORDIC_ITERATIONS = odo_pkg::CORDIC_ITER_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [31:0]         angle,
   output logic                done,
   output logic signed [17:0]  cos_q,
   output logic signed [17:0]  sin_q
);
   localparam int IW = $clog2(CORDIC_ITERATIONS);

   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic               flip_ff, flip_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [IW-1:0]      cnt_ff, cnt_in;
   logic signed [33:0] z_start, sx, sy, atan_v;
   logic signed [33:0] x_out, y_out;

   assign z_start = {{2{angle[31]}}, angle};
   assign sx      = x_ff >>> cnt_ff;
   assign sy      = y_ff >>> cnt_ff;
   assign atan_v  = 34'(odo_pkg::atan_entry(5'(cnt_ff)));

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      flip_in = flip_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = odo_pkg::CORDIC_GAIN;
         y_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         flip_in = 1'b0;
         z_in    = z_start;
         // Angles beyond a quarter turn are folded by a half turn.
         if (z_start > 34'sd1073741824) begin
            z_in    = z_start - 34'sd2147483648;
            flip_in = 1'b1;
         end else if (z_start < -34'sd1073741824) begin
            z_in    = z_start + 34'sd2147483648;
            flip_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_in = x_ff - sy;
            y_in = y_ff + sx;
            z_in = z_ff - atan_v;
         end else begin
            x_in = x_ff + sy;
            y_in = y_ff - sx;
            z_in = z_ff + atan_v;
         end
         cnt_in = IW'(cnt_ff + 1'b1);
         if (cnt_ff == IW'(CORDIC_ITERATIONS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
   end

   assign x_out = flip_ff ? -x_ff : x_ff;
   assign y_out = flip_ff ? -y_ff : y_ff;
   assign done  = done_ff;
   assign cos_q = odo_pkg::round15(x_out);
   assign sin_q = odo_pkg::round15(y_out);

   cordic_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("cordic restarted while busy");

endmodule

[rtl/core/odo_back.sv]
module odo_back #(
   parameter int CORDIC_ITERATIONS = odo_pkg::CORDIC_ITER_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_empty,
   input  odo_pkg::job_type  job_data,
   output logic              job_pop,
   input  logic              rsp_full,
   output logic              rsp_push,
   output odo_pkg::rsp_type  rsp_data
);
   localparam int PB = odo_pkg::POSITION_BITS;
   localparam int QB = odo_pkg::QUOT_BITS;
   localparam logic [24:0] RECIP_HI = odo_pkg::POS_RECIP[48:24];
   localparam logic [23:0] RECIP_LO = odo_pkg::POS_RECIP[23:0];

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_TRIG1 = 4'd1;
   localparam logic [3:0] S_MUL0  = 4'd2;
   localparam logic [3:0] S_MUL1  = 4'd3;
   localparam logic [3:0] S_MUL2  = 4'd4;
   localparam logic [3:0] S_DIV   = 4'd5;
   localparam logic [3:0] S_POS   = 4'd6;
   localparam logic [3:0] S_TRIG2 = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;
   localparam logic [3:0] S_QUO   = 4'd9;

   logic [3:0]           state_ff, state_in;
   odo_pkg::job_type     job_ff;
   logic signed [17:0]   c_ff, s_ff;
   logic [47:0]          msp_ff, myw_ff;
   logic [40:0]          pxh_ff, pxl_ff, pyh_ff, pyl_ff;
   logic [50:0]          hh_ff, hl_ff;
   logic [47:0]          nx_ff, ny_ff;
   logic [47:0]          x00_ff, x10_ff, y00_ff, y10_ff;
   logic [48:0]          x01_ff, x11_ff, y01_ff, y11_ff;
   logic [QB-1:0]        quox_ff, quoy_ff;
   logic signed [PB-1:0] posx_ff, posy_ff;
   logic [31:0]          heading_ff, heading_in;
   logic signed [15:0]   qz_ff, qw_ff;

   logic                 cs_start, cs_done;
   logic [31:0]          cs_angle;
   logic signed [17:0]   cs_cos, cs_sin;

   logic [15:0]          mag_speed, mag_yaw;
   logic [16:0]          mag_c, mag_s;
   logic [63:0]          numx, numy;
   logic [51:0]          hsum;
   logic [96:0]          prodx, prody;

   odo_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cs_start),
      .angle (cs_angle),
      .done  (cs_done),
      .cos_q (cs_cos),
      .sin_q (cs_sin)
   );

   function automatic logic signed [PB-1:0] sat_add(input logic signed [PB-1:0] p,
                                                     input logic [QB-1:0] q,
                                                     input logic neg);
      logic signed [PB:0] d;
      logic signed [PB:0] sum;
      logic signed [PB-1:0] r;
      d   = neg ? -(PB+1)'(q) : (PB+1)'(q);
      sum = {p[PB-1], p} + d;
      if (sum[PB] != sum[PB-1]) begin
         r = sum[PB] ? {1'b1, {(PB-1){1'b0}}} : {1'b0, {(PB-1){1'b1}}};
      end else begin
         r = sum[PB-1:0];
      end
      return r;
   endfunction

   assign mag_speed = job_ff.speed[15] ? 16'(-job_ff.speed) : 16'(job_ff.speed);
   assign mag_yaw   = job_ff.turn_rate[15] ? 16'(-job_ff.turn_rate) : 16'(job_ff.turn_rate);
   assign mag_c     = c_ff[17] ? 17'(-c_ff) : 17'(c_ff);
   assign mag_s     = s_ff[17] ? 17'(-s_ff) : 17'(s_ff);

   assign numx = 64'({pxh_ff, 24'd0}) + 64'(pxl_ff) + odo_pkg::POS_HALF;
   assign numy = 64'({pyh_ff, 24'd0}) + 64'(pyl_ff) + odo_pkg::POS_HALF;
   assign hsum = 52'(hh_ff) + 52'(hl_ff >> 24) + 52'd32768;

   // Full product of the shifted numerator and the reciprocal, from four
   // registered partial products.
   assign prodx = 97'({x11_ff, 48'd0}) + 97'({x01_ff, 24'd0}) + 97'({x10_ff, 24'd0})
                  + 97'(x00_ff);
   assign prody = 97'({y11_ff, 48'd0}) + 97'({y01_ff, 24'd0}) + 97'({y10_ff, 24'd0})
                  + 97'(y00_ff);

   assign job_pop  = (state_ff == S_IDLE) && !job_empty;
   assign cs_start = job_pop || (state_ff == S_POS);
   assign cs_angle = (state_ff == S_POS) ? heading_ff : {heading_ff[30:0], 1'b0};
   assign rsp_push = (state_ff == S_OUT) && !rsp_full;

   always_comb begin
      state_in   = state_ff;
      heading_in = heading_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!job_empty) begin
               state_in = S_TRIG1;
            end
         end
         S_TRIG1: begin
            if (cs_done) begin
               state_in = S_MUL0;
            end
         end
         S_MUL0: state_in = S_MUL1;
         S_MUL1: state_in = S_MUL2;
         S_MUL2: begin
            state_in = S_DIV;
            if (job_ff.turn_rate[15]) begin
               heading_in = heading_ff - hsum[47:16];
            end else begin
               heading_in = heading_ff + hsum[47:16];
            end
         end
         S_DIV: state_in = S_QUO;
         S_QUO: state_in = S_POS;
         S_POS: state_in = S_TRIG2;
         S_TRIG2: begin
            if (cs_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_full) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         heading_ff <= '0;
         posx_ff    <= '0;
         posy_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         heading_ff <= heading_in;
         if (state_ff == S_POS) begin
            posx_ff <= sat_add(posx_ff, quox_ff, job_ff.speed[15] ^ c_ff[17]);
            posy_ff <= sat_add(posy_ff, quoy_ff, job_ff.speed[15] ^ s_ff[17]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff <= job_data;
      end
      if (state_ff == S_TRIG1 && cs_done) begin
         c_ff <= cs_cos;
         s_ff <= cs_sin;
      end
      if (state_ff == S_TRIG2 && cs_done) begin
         qw_ff <= odo_pkg::sat16(cs_cos);
         qz_ff <= odo_pkg::sat16(cs_sin);
      end
      if (state_ff == S_MUL0) begin
         msp_ff <= mag_speed * job_ff.dt;
         myw_ff <= mag_yaw * job_ff.dt;
      end
      if (state_ff == S_MUL1) begin
         pxh_ff <= msp_ff[47:24] * mag_c;
         pxl_ff <= msp_ff[23:0] * mag_c;
         pyh_ff <= msp_ff[47:24] * mag_s;
         pyl_ff <= msp_ff[23:0] * mag_s;
         hh_ff  <= myw_ff[47:24] * odo_pkg::HEADING_GAIN;
         hl_ff  <= myw_ff[23:0] * odo_pkg::HEADING_GAIN;
      end
      if (state_ff == S_MUL2) begin
         nx_ff <= numx[63:16];
         ny_ff <= numy[63:16];
      end
      if (state_ff == S_DIV) begin
         x00_ff <= nx_ff[23:0] * RECIP_LO;
         x01_ff <= nx_ff[23:0] * RECIP_HI;
         x10_ff <= nx_ff[47:24] * RECIP_LO;
         x11_ff <= nx_ff[47:24] * RECIP_HI;
         y00_ff <= ny_ff[23:0] * RECIP_LO;
         y01_ff <= ny_ff[23:0] * RECIP_HI;
         y10_ff <= ny_ff[47:24] * RECIP_LO;
         y11_ff <= ny_ff[47:24] * RECIP_HI;
      end
      if (state_ff == S_QUO) begin
         quox_ff <= prodx[69 +: QB];
         quoy_ff <= prody[69 +: QB];
      end
   end

   assign rsp_data.stamp_out     = job_ff.stamp;
   assign rsp_data.pos_x         = posx_ff;
   assign rsp_data.pos_y         = posy_ff;
   assign rsp_data.heading       = heading_ff;
   assign rsp_data.quat_z        = qz_ff;
   assign rsp_data.quat_w        = qw_ff;
   assign rsp_data.speed_out     = job_ff.speed;
   assign rsp_data.turn_rate_out = job_ff.turn_rate;

   push_has_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full) else $error("result pushed into a full queue");

   pop_has_job: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> state_ff == S_TRIG1) else $error("job pop did not start the sequence");

   heading_moves_once: assert property (@(posedge clock) disable iff (reset)
      (heading_ff != $past(heading_ff)) |-> ($past(state_ff) == S_MUL2 || $past(reset)))
      else $error("heading changed outside its update step");

endmodule

[rtl/core/planar_dead_reckoning_odometry_unit.sv]
// Planar dead-reckoning odometry unit.
// Requests (stamp in ns, speed, yaw rate) enter through a queue-style port:
// a request is taken at a clock edge where push is high and full is low.
// Poses leave through a second queue: while empty is low, the oldest pose is
// on rsp_data, and it is taken at an edge where pop is high.
// The front end keeps the last stamp, forms dt and drops requests that yield
// no pose (first sample, zero last stamp, or a stamp not later than the last).
// A two-entry queue hands the rest to the back end, which runs the CORDIC on
// the old heading, the position products and the heading step, a reciprocal
// multiply for each axis and the CORDIC on the new heading.
// The back end takes the next job only after it has pushed the last pose; its
// time per pose is set mostly by the two CORDIC passes.
// Synchronous reset clears stamp, position, heading and both queues.
// If the receiver stops popping, two poses wait in the result queue, then
// the back end holds, the request queue fills and full rises.
module planar_dead_reckoning_odometry_unit #(
   parameter int CORDIC_ITERATIONS = odo_pkg::CORDIC_ITER_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  odo_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output odo_pkg::rsp_type rsp_data
);
   logic             job_push, job_full, job_empty, job_pop;
   odo_pkg::job_type job_wdata, job_rdata;
   logic             rsp_push, rsp_full;
   odo_pkg::rsp_type rsp_wdata;

   odo_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .job_full (job_full),
      .full     (full),
      .job_push (job_push),
      .job_data (job_wdata)
   );

   odo_fifo #(.WIDTH($bits(odo_pkg::job_type)), .DEPTH(2)) u_job_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_push),
      .wr_data (job_wdata),
      .full    (job_full),
      .rd_en   (job_pop),
      .rd_data (job_rdata),
      .empty   (job_empty)
   );

   odo_back #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_data  (job_rdata),
      .job_pop   (job_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_wdata)
   );

   odo_fifo #(.WIDTH($bits(odo_pkg::rsp_type)), .DEPTH(2)) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_push),
      .wr_data (rsp_wdata),
      .full    (rsp_full),
      .rd_en   (pop),
      .rd_data (rsp_data),
      .empty   (empty)
   );

endmodule

[verif/planar_dead_reckoning_odometry_unit_tb.sv]
`timescale 1ns / 1ps

module planar_dead_reckoning_odometry_unit_tb;

   localparam longint unsigned STAMP_MASK = 64'h7fff_ffff_ffff_ffff;
   localparam int              HOLD_CYCLES = 400;

   typedef struct {
      odo_pkg::req_type req;
      bit               no_pose;
   } row_type;

   logic             clock;
   logic             reset;
   logic             push;
   logic             full;
   odo_pkg::req_type req_data;
   logic             empty;
   logic             pop;
   odo_pkg::rsp_type rsp_data;

   // Dead-reckoning state kept by the testbench.
   logic [62:0] prev_stamp;
   longint      track_x;
   longint      track_y;
   logic [31:0] track_heading;

   odo_pkg::rsp_type pose_q[$];
   int      error_count;
   int      pose_count;
   int      drop_count;
   bit      calm;
   bit      held_once;

   planar_dead_reckoning_odometry_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[planar_dead_reckoning_odometry_unit] ERROR");
      $finish;
   end

   task automatic report(input string what, input longint got, input longint want);
      error_count++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
   endtask

   function automatic longint round_q15(input longint v);
      longint unsigned mag;
      longint          m;
      mag = (v < 0) ? -v : v;
      m   = longint'((mag + 16384) >> 15);
      return (v < 0) ? -m : m;
   endfunction

   // Rotation CORDIC, 2^32 counts per turn, Q1.15 results before saturation.
   function automatic void cordic_sin_cos(input logic [31:0] ang, output longint c,
                                          output longint s);
      longint z;
      longint x;
      longint y;
      longint dx;
      longint dy;
      bit     flip;
      z    = longint'($signed(ang));
      x    = longint'(odo_pkg::CORDIC_GAIN);
      y    = 0;
      flip = 1'b0;
      if (z > 64'sd1073741824 || z < -64'sd1073741824) begin
         z    = (z > 0) ? z - 64'sd2147483648 : z + 64'sd2147483648;
         flip = 1'b1;
      end
      for (int i = 0; i < odo_pkg::CORDIC_ITER_DEF; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - longint'(odo_pkg::atan_entry(5'(i)));
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + longint'(odo_pkg::atan_entry(5'(i)));
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = round_q15(x);
      s = round_q15(y);
   endfunction

   function automatic longint travel_step(input longint unsigned m, input bit neg_speed,
                                          input longint trig);
      longint unsigned mag;
      longint unsigned q;
      mag = (trig < 0) ? -trig : trig;
      q   = (m * mag + 64'd64000000000) / 64'd128000000000;
      return (neg_speed != (trig < 0)) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint clamp_position(input longint p, input longint d);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (odo_pkg::POSITION_BITS - 1)) - 1;
      lo = -hi - 1;
      if (d > 0 && p > hi - d) return hi;
      if (d < 0 && p < lo - d) return lo;
      return p + d;
   endfunction

   function automatic logic signed [15:0] clamp16(input longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
   endfunction

   // Advances the tracked pose by one request; returns 1 when a pose is due.
   function automatic bit advance_pose(input odo_pkg::req_type r);
      logic [62:0]      last;
      longint unsigned  dt;
      longint unsigned  m;
      longint unsigned  hi;
      longint unsigned  lo;
      longint unsigned  q;
      longint           c;
      longint           s;
      longint           qw;
      longint           qz;
      odo_pkg::rsp_type p;
      bit               neg;
      last       = prev_stamp;
      prev_stamp = r.stamp_ns;
      if (last == 0 || r.stamp_ns <= last) return 1'b0;
      dt = r.stamp_ns - last;
      if (dt > 64'hffff_ffff) dt = 64'hffff_ffff;

      cordic_sin_cos({track_heading[30:0], 1'b0}, c, s);
      neg     = r.speed < 0;
      m       = longint'(neg ? -int'(r.speed) : int'(r.speed)) * dt;
      track_x = clamp_position(track_x, travel_step(m, neg, c));
      track_y = clamp_position(track_y, travel_step(m, neg, s));

      m  = longint'((r.turn_rate < 0) ? -int'(r.turn_rate) : int'(r.turn_rate)) * dt;
      hi = (m >> 24) * 64'd91746578;
      lo = (m & 64'hff_ffff) * 64'd91746578;
      q  = (hi + (lo >> 24) + 64'd32768) >> 16;
      if (r.turn_rate < 0) begin
         track_heading = track_heading - q[31:0];
      end else begin
         track_heading = track_heading + q[31:0];
      end
      cordic_sin_cos(track_heading, qw, qz);

      p.stamp_out     = r.stamp_ns;
      p.pos_x         = track_x[odo_pkg::POSITION_BITS-1:0];
      p.pos_y         = track_y[odo_pkg::POSITION_BITS-1:0];
      p.heading       = track_heading;
      p.quat_z        = clamp16(qz);
      p.quat_w        = clamp16(qw);
      p.speed_out     = r.speed;
      p.turn_rate_out = r.turn_rate;
      pose_q.push_back(p);
      return 1'b1;
   endfunction

   task automatic send_request(input odo_pkg::req_type r, output bit made_pose);
      if (!calm && $urandom_range(99) < 13) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      made_pose = advance_pose(r);
      if (made_pose) pose_count++;
      else drop_count++;
   endtask

   // Result side: check every accepted pose, stall at random, and once
   // hold off long enough for both queues to fill.
   initial begin
      odo_pkg::rsp_type want;
      int               hold_left;
      int               checked;
      pop       = 1'b0;
      hold_left = 0;
      checked   = 0;
      held_once = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (pop && !empty) begin
            checked++;
            if (pose_q.size() == 0) begin
               report("unexpected pose, stamp", longint'(rsp_data.stamp_out), -1);
            end else begin
               want = pose_q.pop_front();
               if (rsp_data.stamp_out != want.stamp_out)
                  report("stamp_out", rsp_data.stamp_out, want.stamp_out);
               if (rsp_data.pos_x != want.pos_x)
                  report("pos_x", rsp_data.pos_x, want.pos_x);
               if (rsp_data.pos_y != want.pos_y)
                  report("pos_y", rsp_data.pos_y, want.pos_y);
               if (rsp_data.heading != want.heading)
                  report("heading", rsp_data.heading, want.heading);
               if (rsp_data.quat_z != want.quat_z)
                  report("quat_z", rsp_data.quat_z, want.quat_z);
               if (rsp_data.quat_w != want.quat_w)
                  report("quat_w", rsp_data.quat_w, want.quat_w);
               if (rsp_data.speed_out != want.speed_out)
                  report("speed_out", rsp_data.speed_out, want.speed_out);
               if (rsp_data.turn_rate_out != want.turn_rate_out)
                  report("turn_rate_out", rsp_data.turn_rate_out, want.turn_rate_out);
            end
         end
         if (!held_once && checked == 120) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= calm || $urandom_range(99) >= 13;
         end
      end
   end

   initial begin
      row_type          rows[$];
      odo_pkg::req_type r;
      bit               made;
      longint unsigned  cur;
      int               k;
      int               wait_cycles;

      push        = 1'b0;
      req_data    = '0;
      reset       = 1'b1;
      prev_stamp  = '0;
      track_x     = 0;
      track_y     = 0;
      track_heading = '0;
      error_count = 0;
      pose_count  = 0;
      drop_count  = 0;
      calm        = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: first sample, repeated and earlier stamps, large gaps,
      // field extremes, a zero stamp, and heading wrap from long gaps.
      rows.push_back('{'{63'd1000, 16'sd0, 16'sd0}, 1'b1});
      rows.push_back('{'{63'd2000, 16'sd32767, 16'sd0}, 1'b0});
      rows.push_back('{'{63'd2000, 16'sd5, 16'sd5}, 1'b1});
      rows.push_back('{'{63'd1500, 16'sd5, 16'sd5}, 1'b1});
      rows.push_back('{'{63'd1500 + (63'd1 << 33), -16'sd32768, 16'sd32767}, 1'b0});
      rows.push_back('{'{63'h7fff_ffff_ffff_ffff, 16'sd32767, -16'sd32768}, 1'b0});
      rows.push_back('{'{63'd0, 16'sd1, 16'sd1}, 1'b1});
      rows.push_back('{'{63'd5, 16'sd1, 16'sd1}, 1'b1});
      rows.push_back('{'{63'd100, 16'sd256, 16'sd4096}, 1'b0});
      rows.push_back('{'{63'd100 + 63'hffff_ffff, 16'sd32767, 16'sd32767}, 1'b0});
      rows.push_back('{'{63'd200 + (63'h1 << 34), -16'sd1, 16'sd32767}, 1'b0});
      rows.push_back('{'{63'd300 + (63'h1 << 35), 16'sd1, 16'sd32767}, 1'b0});
      rows.push_back('{'{63'd400 + (63'h1 << 36), -16'sd32768, -16'sd32768}, 1'b0});
      rows.push_back('{'{63'd400 + (63'h1 << 36) + 63'd1, -16'sd32768, -16'sd1}, 1'b0});
      rows.push_back('{'{63'd1 << 40, 16'sd0, -16'sd32768}, 1'b0});
      rows.push_back('{'{(63'd1 << 40) + 63'd20_000_000, 16'sd12345, 16'sd0}, 1'b0});
      foreach (rows[i]) begin
         send_request(rows[i].req, made);
         if (made == rows[i].no_pose)
            report("pose presence, row", made, !rows[i].no_pose);
      end

      // Random part: mostly steadily rising stamps, with repeats, steps back,
      // long gaps, zero and fully random stamps mixed in.
      cur = 64'd1 << 41;
      k   = 0;
      while (k < 834) begin
         calm = (k >= 400 && k < 550);
         wait_cycles = $urandom_range(99);
         if (wait_cycles < 70) begin
            cur = cur + $urandom_range(1, 50_000_000);
         end else if (wait_cycles < 80) begin
            cur = cur + (longint'($urandom) << $urandom_range(0, 12));
         end else if (wait_cycles < 86) begin
            cur = cur;
         end else if (wait_cycles < 91) begin
            cur = cur - $urandom_range(0, 1000);
         end else if (wait_cycles < 97) begin
            cur = {$urandom, $urandom};
         end else begin
            cur = 0;
         end
         cur = cur & STAMP_MASK;
         r.stamp_ns  = cur[62:0];
         r.speed     = 16'($urandom);
         r.turn_rate = 16'($urandom);
         send_request(r, made);
         k++;
      end
      calm = 1'b0;
      push <= 1'b0;

      while (pose_q.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);

      $display("Covered %0d poses and %0d dropped requests, including a long output stall.",
               pose_count, drop_count);
      if (error_count == 0) begin
         $display("[planar_dead_reckoning_odometry_unit] OK");
      end else begin
         $display("[planar_dead_reckoning_odometry_unit] ERROR");
      end
      $finish;
   end

endmodule
